/* src/xoshiro256pp_byte_generator_defines.svh */
// Assertion macros shared by the xoshiro256++ byte generator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
// Included by the modules that carry concurrent assertions.
`ifndef XOSHIRO256PP_BYTE_GENERATOR_DEFINES_SVH
`define XOSHIRO256PP_BYTE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge.
`define XBG_ASSERT(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("xbg assertion failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define XBG_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xbg assertion failed");

// Check that a consequent holds in the cycle after its antecedent.
`define XBG_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xbg assertion failed");

`else

`define XBG_ASSERT(name, cond)
`define XBG_ASSERT_IMPL(name, ante, cons)
`define XBG_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* src/xbg_pkg.sv */
// Types and constants for the xoshiro256++ byte generator.
// Used by xbg_ctrl, xbg_datapath and the top level; depends on nothing.
package xbg_pkg;

    // splitmix64 and request constants
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_1    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_2    = 64'h94D049BB133111EB;

    localparam int unsigned MAX_FILL_BYTES = 64;
    localparam int unsigned WORD_BYTES     = 8;
    localparam int unsigned MAX_WORDS      = 8;
    localparam int unsigned FILL_LIMIT     = (MAX_FILL_BYTES < MAX_WORDS * WORD_BYTES) ?
                                             MAX_FILL_BYTES : MAX_WORDS * WORD_BYTES;

    localparam int unsigned COUNT_W = 7;
    localparam logic [COUNT_W-1:0] FILL_LIMIT_C = COUNT_W'(FILL_LIMIT);
    localparam logic [COUNT_W-1:0] WORD_BYTES_C = COUNT_W'(WORD_BYTES);

    // Seeding sequencer: last step of a splitmix64 word, last word of a seed
    localparam logic [3:0] SEED_LAST_STEP = 4'd8;
    localparam logic [1:0] SEED_LAST_WORD = 2'd3;

    // Input mode codes
    localparam logic MODE_SEED     = 1'b0;
    localparam logic MODE_GENERATE = 1'b1;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_LOAD_SEED = 3'd1,
        OP_MIX_START = 3'd2,
        OP_MUL       = 3'd3,
        OP_XSH       = 3'd4,
        OP_STORE     = 3'd5,
        OP_ADV_SUM   = 3'd6,
        OP_ADV_STEP  = 3'd7
    } dp_op_t;

    // Partial products of a 64x64 low-half multiply
    localparam logic [1:0] MUL_LO_LO = 2'd0;
    localparam logic [1:0] MUL_HI_LO = 2'd1;
    localparam logic [1:0] MUL_LO_HI = 2'd2;

    typedef struct packed {
        dp_op_t     op;
        logic       src_fallback;  // load seed from the fallback register
        logic [1:0] mul_step;      // partial product select
        logic       mul_sel;       // 0: first mix constant, 1: second
        logic [3:0] valid_bytes;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;            // output register can take a word this cycle
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEED = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_STEP = 4'b1000
    } ctrl_state_t;

endpackage

/* src/xbg_ctrl.sv */
// Controller for the xoshiro256++ byte generator: accepts items, sequences
// seeding and word generation. Depends on xbg_pkg and the assertion header.
`include "xoshiro256pp_byte_generator_defines.svh"

module xbg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_mode,
    input  logic [6:0]           in_count,
    output xbg_pkg::dp_cmd_t     cmd,
    input  xbg_pkg::dp_status_t  status
);
    import xbg_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [3:0]           step_reg, step_next;
    logic [1:0]           word_reg, word_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 gen_reg, gen_next;
    logic                 seeded_reg, seeded_next;

    logic [COUNT_W-1:0]   count_sat;
    logic [COUNT_W-1:0]   chunk;
    logic                 accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Clamp the request to what one item may return
    assign count_sat = (in_count > FILL_LIMIT_C) ? FILL_LIMIT_C : in_count;
    assign chunk     = (count_reg > WORD_BYTES_C) ? WORD_BYTES_C : count_reg;

    // Next state and datapath command
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        word_next    = word_reg;
        count_next   = count_reg;
        gen_next     = gen_reg;
        seeded_next  = seeded_reg;
        cmd          = '0;
        cmd.op       = OP_NONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next  = '0;
                    word_next  = '0;
                    count_next = count_sat;
                    if (in_mode == MODE_SEED || !seeded_reg)
                    begin
                        cmd.op           = OP_LOAD_SEED;
                        cmd.src_fallback = (in_mode == MODE_GENERATE);
                        seeded_next      = 1'b1;
                        gen_next         = (in_mode == MODE_GENERATE);
                        state_next       = ST_SEED;
                    end
                    else if (count_sat != '0)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end

            ST_SEED:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        cmd.op = OP_MIX_START;
                    end
                    4'd1, 4'd2, 4'd3:
                    begin
                        cmd.op       = OP_MUL;
                        cmd.mul_step = step_reg[1:0] - 2'd1;
                        cmd.mul_sel  = 1'b0;
                    end
                    4'd4:
                    begin
                        cmd.op = OP_XSH;
                    end
                    4'd5, 4'd6, 4'd7:
                    begin
                        cmd.op       = OP_MUL;
                        cmd.mul_step = step_reg[1:0] - 2'd1;
                        cmd.mul_sel  = 1'b1;
                    end
                    default:
                    begin
                        cmd.op = OP_STORE;
                    end
                endcase

                if (step_reg == SEED_LAST_STEP)
                begin
                    step_next = '0;
                    word_next = word_reg + 2'd1;
                    if (word_reg == SEED_LAST_WORD)
                    begin
                        state_next = (gen_reg && count_reg != '0) ? ST_SUM : ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end

            ST_SUM:
            begin
                cmd.op     = OP_ADV_SUM;
                state_next = ST_STEP;
            end

            ST_STEP:
            begin
                // Hold until the output register can take the word
                if (status.out_free)
                begin
                    cmd.op          = OP_ADV_STEP;
                    cmd.valid_bytes = chunk[3:0];
                    cmd.last        = (count_reg <= WORD_BYTES_C);
                    count_next      = count_reg - chunk;
                    state_next      = (count_reg <= WORD_BYTES_C) ? ST_IDLE : ST_SUM;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            word_reg   <= '0;
            count_reg  <= '0;
            gen_reg    <= 1'b0;
            seeded_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            word_reg   <= word_next;
            count_reg  <= count_next;
            gen_reg    <= gen_next;
            seeded_reg <= seeded_next;
        end
    end

    `XBG_ASSERT_IMPL(a_emit_needs_room, cmd.op == OP_ADV_STEP, status.out_free)
    `XBG_ASSERT_NEXT(a_more_words_follow, cmd.op == OP_ADV_STEP && !cmd.last, state_reg == ST_SUM)
    `XBG_ASSERT_NEXT(a_seeded_sticky, seeded_reg, seeded_reg)
    `XBG_ASSERT_IMPL(a_emit_only_seeded, cmd.op == OP_ADV_STEP, seeded_reg && count_reg != '0)

endmodule

/* src/xbg_datapath.sv */
// Datapath for the xoshiro256++ byte generator: splitmix64 seeding with a
// shared 32x32 multiplier, state advance and output register. Uses xbg_pkg.
module xbg_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [63:0]          cfg_wr_data,
    input  logic [63:0]          seed_in,
    input  xbg_pkg::dp_cmd_t     cmd,
    output xbg_pkg::dp_status_t  status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          out_word,
    output logic [3:0]           out_valid_bytes,
    output logic                 out_last
);
    import xbg_pkg::*;

    logic [63:0] fallback_reg;
    logic [63:0] acc_reg;
    logic [63:0] z_reg;
    logic [63:0] p_reg;
    logic [63:0] s0_reg, s1_reg, s2_reg, s3_reg;
    logic [63:0] word_reg;
    logic [3:0]  vb_reg;
    logic        last_reg;
    logic        valid_reg, valid_next;

    logic [63:0] mix_sum;
    logic [63:0] mul_const;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;
    logic [63:0] rot_sum;
    logic [63:0] t17, s2_x, s3_x, s1_x, s0_x;

    // Fallback seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            fallback_reg <= cfg_wr_data;
        end
    end

    // Shared multiplier: one 32x32 partial product per cycle
    assign mix_sum   = acc_reg + GOLDEN_GAMMA;
    assign mul_const = cmd.mul_sel ? MIX_MUL_2 : MIX_MUL_1;
    assign mul_a     = (cmd.mul_step == MUL_HI_LO) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b     = (cmd.mul_step == MUL_LO_HI) ? mul_const[63:32] : mul_const[31:0];
    assign mul_prod  = 64'(mul_a) * 64'(mul_b);

    // xoshiro256++ output and state update
    assign rot_sum = {z_reg[40:0], z_reg[63:41]} + s0_reg;
    assign t17     = s1_reg << 17;
    assign s2_x    = s2_reg ^ s0_reg;
    assign s3_x    = s3_reg ^ s1_reg;
    assign s1_x    = s1_reg ^ s2_x;
    assign s0_x    = s0_reg ^ s3_x;

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD_SEED:
            begin
                acc_reg <= cmd.src_fallback ? fallback_reg : seed_in;
            end
            OP_MIX_START:
            begin
                acc_reg <= mix_sum;
                z_reg   <= mix_sum ^ (mix_sum >> 30);
            end
            OP_MUL:
            begin
                if (cmd.mul_step == MUL_LO_LO)
                begin
                    p_reg <= mul_prod;
                end
                else
                begin
                    p_reg <= {p_reg[63:32] + mul_prod[31:0], p_reg[31:0]};
                end
            end
            OP_XSH:
            begin
                z_reg <= p_reg ^ (p_reg >> 27);
            end
            OP_STORE:
            begin
                s0_reg <= s1_reg;
                s1_reg <= s2_reg;
                s2_reg <= s3_reg;
                s3_reg <= p_reg ^ (p_reg >> 31);
            end
            OP_ADV_SUM:
            begin
                z_reg <= s0_reg + s3_reg;
            end
            OP_ADV_STEP:
            begin
                word_reg <= rot_sum;
                vb_reg   <= cmd.valid_bytes;
                last_reg <= cmd.last;
                s0_reg   <= s0_x;
                s1_reg   <= s1_x;
                s2_reg   <= s2_x ^ t17;
                s3_reg   <= {s3_x[18:0], s3_x[63:19]};
            end
            default:
            begin
            end
        endcase
    end

    // Output valid: set on a new word, drop when taken
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.op == OP_ADV_STEP)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign status.out_free = !valid_reg || out_ready;
    assign out_valid       = valid_reg;
    assign out_word        = word_reg;
    assign out_valid_bytes = vb_reg;
    assign out_last        = last_reg;

endmodule

/* src/xoshiro256pp_byte_generator.sv */
// xoshiro256++ random byte generator with splitmix64 seeding.
// Input items on s_axis: tuser is the mode (0 seed, 1 generate), tdata holds
// the 64-bit seed and the 7-bit byte count. A seed item returns nothing.
// A generate item returns one 64-bit word per eight requested bytes (up to
// eight words) on m_axis; the final word has tlast and its valid byte count.
// Before the first seed item a generate item seeds from fallback_seed,
// written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the block is idle, which the block itself does not enforce. Seeding runs
// four splitmix64 words through one shared 32x32 multiplier: mix start,
// multiply, xor-shift, multiply, store. Each output word takes an add, then a
// rotate-add with state update that waits until the output register is free.
// A new item is accepted once the previous one has produced its last word;
// that word may still sit in the output register. When the receiver stalls,
// the output register holds its word and generation pauses until it drains.
// Reset clears the state to unseeded and the fallback seed to zero; no
// clearing pass is needed, input is accepted in the first cycle after reset.
module xoshiro256pp_byte_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] seed_value, [70:64] byte_count, [71] zero
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] random_word, [67:64] valid_bytes, [71:68] zero
    output logic        m_axis_tlast
);
    import xbg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [63:0] word;
    logic [3:0]  valid_bytes;

    xbg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tuser),
        .in_count (s_axis_tdata[70:64]),
        .cmd      (cmd),
        .status   (status)
    );

    xbg_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .seed_in         (s_axis_tdata[63:0]),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_word        (word),
        .out_valid_bytes (valid_bytes),
        .out_last        (m_axis_tlast)
    );

    // Pack the output item
    assign m_axis_tdata = {4'b0000, valid_bytes, word};

endmodule

/* tb/xbg_stream_checker.sv */
// Stream checker for the xoshiro256++ byte generator: predicts the words that
// each accepted request should return and compares them with the output stream.
// Depends on xbg_pkg for the mode codes and on the port signals of the block.
module xbg_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] seed_value, [70:64] byte_count, [71] zero
    input  logic        s_axis_tuser,   // [0] mode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,   // [63:0] random_word, [67:64] valid_bytes, [71:68] zero
    input  logic        m_axis_tlast,
    output int          error_count,
    output int          pending_words,
    output int          words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import xbg_pkg::*;

    // splitmix64 increment and mixing multipliers
    localparam logic [63:0] MIX_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_K1    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_K2    = 64'h94D049BB133111EB;
    localparam logic [6:0]  BYTE_CAP  = 7'd64;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } rand_word_t;

    logic [63:0] gen_state [4];
    logic        seeded;
    logic [63:0] fallback_seed;
    rand_word_t  expected_words [$];

    int          err_total;
    int          checked_total;
    logic [6:0]  bytes_left;
    logic [3:0]  chunk;
    rand_word_t  got;
    rand_word_t  want;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned amt);
        return (v << amt) | (v >> (64 - amt));
    endfunction

    function automatic logic [63:0] splitmix_step(inout logic [63:0] acc);
        logic [63:0] z;
        acc = acc + MIX_GAMMA;
        z = acc;
        z = (z ^ (z >> 30)) * MIX_K1;
        z = (z ^ (z >> 27)) * MIX_K2;
        return z ^ (z >> 31);
    endfunction

    // Fill all four state words from one 64-bit seed
    task automatic reseed(input logic [63:0] seed);
        logic [63:0] acc;
        acc = seed;
        for (int i = 0; i < 4; i++)
        begin
            gen_state[i] = splitmix_step(acc);
        end
        seeded = 1'b1;
    endtask

    // Produce one output word and step the state
    function automatic logic [63:0] xoshiro_next();
        logic [63:0] word;
        logic [63:0] shifted;
        word = rotl64(gen_state[0] + gen_state[3], 23) + gen_state[0];
        shifted = gen_state[1] << 17;
        gen_state[2] ^= gen_state[0];
        gen_state[3] ^= gen_state[1];
        gen_state[1] ^= gen_state[2];
        gen_state[0] ^= gen_state[3];
        gen_state[2] ^= shifted;
        gen_state[3] = rotl64(gen_state[3], 45);
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                gen_state[i] = '0;
            end
            seeded = 1'b0;
            fallback_seed = '0;
            expected_words.delete();
            err_total = 0;
            checked_total = 0;
        end
        else
        begin
            // Track the fallback register
            if (cfg_wr_en)
                fallback_seed = cfg_wr_data;

            // Compare an accepted word with the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.word   = m_axis_tdata[63:0];
                got.nbytes = m_axis_tdata[67:64];
                got.last   = m_axis_tlast;
                if (expected_words.size() == 0)
                begin
                    err_total++;
                    $display("%0t: unexpected word: expected none, got word %h valid %0d last %b",
                             $time, got.word, got.nbytes, got.last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    checked_total++;
                    if (got.word !== want.word || got.nbytes !== want.nbytes ||
                        got.last !== want.last)
                    begin
                        err_total++;
                        $display("%0t: mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                 $time, want.word, want.nbytes, want.last,
                                 got.word, got.nbytes, got.last);
                    end
                end
            end

            // Predict the words of an accepted item
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == MODE_SEED)
                    reseed(s_axis_tdata[63:0]);
                else
                begin
                    if (!seeded)
                        reseed(fallback_seed);
                    bytes_left = s_axis_tdata[70:64];
                    if (bytes_left > BYTE_CAP)
                        bytes_left = BYTE_CAP;
                    while (bytes_left > 0)
                    begin
                        chunk = (bytes_left > 7'd8) ? 4'd8 : bytes_left[3:0];
                        bytes_left = bytes_left - 7'(chunk);
                        want.word   = xoshiro_next();
                        want.nbytes = chunk;
                        want.last   = (bytes_left == 0);
                        expected_words.push_back(want);
                    end
                end
            end
        end
        error_count   <= err_total;
        pending_words <= expected_words.size();
        words_checked <= checked_total;
    end

endmodule

/* tb/testbench.sv */
// Top of the xoshiro256++ byte generator testbench: clock, reset, stimulus,
// idling profiles, watchdog and verdict. Depends on xbg_pkg, the block and
// xbg_stream_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xbg_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PER_PHASE = 32;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [63:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // [63:0] seed_value, [70:64] byte_count, [71] zero
    logic        s_axis_tuser;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // [63:0] random_word, [67:64] valid_bytes, [71:68] zero
    logic        m_axis_tlast;

    int          error_count;
    int          pending_words;
    int          words_checked;

    int          src_idle_pct;
    int          sink_idle_pct;
    bit          hold_pending;
    int          seeds_sent;
    int          requests_sent;
    int          quiet_cycles;

    xoshiro256pp_byte_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    xbg_stream_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .error_count   (error_count),
        .pending_words (pending_words),
        .words_checked (words_checked)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && hold_pending)
            begin
                stall_left = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no traffic for %0d cycles, %0d words outstanding",
                     $time, WATCHDOG_LIMIT, pending_words);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one item and hold it until accepted
    task automatic send_item(input logic mode, input logic [63:0] seed,
                             input logic [6:0] count);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, count, seed};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (mode == MODE_SEED)
            seeds_sent++;
        else
            requests_sent++;
    endtask

    task automatic send_request(input logic [6:0] count);
        send_item(MODE_GENERATE, {$urandom, $urandom}, count);
    endtask

    task automatic send_seed(input logic [63:0] seed);
        send_item(MODE_SEED, seed, 7'($urandom));
    endtask

    // Drop valid and wait until every expected word is back and the block has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_fallback(input logic [63:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly requests of legal size, some oversized or empty, some reseeds
    task automatic send_random(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_seed({$urandom, $urandom});
            else if (pick < 22)
                send_request(7'($urandom_range(65, 127)));
            else if (pick < 27)
                send_request(7'd0);
            else
                send_request(7'($urandom_range(1, 64)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_pending  = 1'b0;
        seeds_sent    = 0;
        requests_sent = 0;
        quiet_cycles  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: sender rarely idle, receiver often stalled
        src_idle_pct  = 10;
        sink_idle_pct = 72;
        write_fallback(64'hFFFF_FFFF_FFFF_FFFF);

        // Empty request while unseeded still seeds from the fallback
        send_request(7'd0);
        send_request(7'd8);
        send_request(7'd1);
        send_request(7'd127);
        send_seed(64'h0);
        send_request(7'd64);
        send_request(7'd65);
        // Pause the sender until every word is back
        drain();
        send_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_request(7'd7);
        send_request(7'd9);
        send_request(7'd15);
        send_request(7'd16);
        send_seed(64'h8000_0000_0000_0001);
        send_request(7'd63);
        send_request(7'd0);
        send_seed({$urandom, $urandom});
        send_request(7'd100);
        send_request(7'd2);
        send_random(RANDOM_PER_PHASE);
        drain();

        // Phase 2: sender often idle, receiver rarely stalled
        write_fallback(64'h0);
        src_idle_pct  = 72;
        sink_idle_pct = 10;
        send_random(RANDOM_PER_PHASE);
        drain();

        // Phase 3: no idling, with one long receiver hold-off under full requests
        write_fallback({$urandom, $urandom});
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_pending  = 1'b1;
        repeat (6) send_request(7'd64);
        send_random(RANDOM_PER_PHASE);
        drain();

        if (pending_words != 0)
            $display("%0t: %0d expected words never arrived", $time, pending_words);
        $display("Ran %0d seed items and %0d byte requests; %0d words checked across",
                 seeds_sent, requests_sent, words_checked);
        $display("three idling profiles, fallback seeding, saturation and a long output stall.");
        if (error_count == 0 && pending_words == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
